// ===== rtl/bbx_pkg.sv =====
// Shared constants, codes and types of the 3x3 box blur block.
`default_nettype none

package bbx_pkg;

	// Line store depth and width, and the column width that follows from the depth
	localparam int MAX_WIDTH   = 1024;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int LINE_W      = 2 * 8;

	// Field and register widths
	localparam int PIX_W       = 8;
	localparam int CFG_WIDTH_W = 11;
	localparam int HEIGHT_W    = 16;
	localparam int ROW_CNT_W   = 17;
	localparam int COUNT_W     = 26;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [ROW_CNT_W-1:0] ROW_CNT_MAX = '1;

	// Window sum and the reciprocal used for the divide by nine
	localparam int SUM_W       = 12;
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(9 * 255);
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 16;
	localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(((1 << RECIP_SHIFT) / 9) + 1);
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam logic [PIX_W:0] GREY_MAX = (PIX_W + 1)'(255);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

	// One window column, top row first
	typedef pix_t [2:0] col_t;

	// Window rows and columns that fall outside the image
	typedef struct packed {
		logic left_off;
		logic right_off;
		logic top_off;
		logic bottom_off;
	} mask_t;

	// Result on its way to the divider
	typedef struct packed {
		logic [SUM_W-1:0]    sum;
		logic [COL_W-1:0]    column;
		logic [HEIGHT_W-1:0] row;
		logic                last;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/bbx_channels.sv =====
// Channel interfaces: pixel input, grey result output and register writes.
`default_nettype none

interface bbx_pix_if;
	logic                     valid;
	logic                     ready;
	logic [bbx_pkg::PIX_W-1:0] red_value;
	logic                     flush;

	modport source (output valid, output red_value, output flush, input ready);
	modport sink   (input valid, input red_value, input flush, output ready);
endinterface

interface bbx_out_if;
	logic                        valid;
	logic                        ready;
	logic [bbx_pkg::PIX_W-1:0]    grey_value;
	logic [bbx_pkg::COL_W-1:0]    column;
	logic [bbx_pkg::HEIGHT_W-1:0] row;
	logic                        last;

	modport source (output valid, output grey_value, output column, output row,
		output last, input ready);
	modport sink   (input valid, input grey_value, input column, input row,
		input last, output ready);
endinterface

interface bbx_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bbx_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [bbx_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/bbx_line_ram.sv =====
// Simple dual-port RAM, registered read, write-first on an address clash.
`default_nettype none

module bbx_line_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, new data passed through when both ports hit one entry
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bbx_window.sv =====
// 3x3 window registers and the masked neighbourhood sum.
`default_nettype none

module bbx_window (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  shift,
	input  wire bbx_pkg::col_t         new_col,
	input  wire bbx_pkg::mask_t        mask,
	output      logic [bbx_pkg::SUM_W-1:0] sum
);
	import bbx_pkg::*;

	// Only the two newest columns are kept; the oldest drops out on a shift
	col_t win1_q;
	col_t win2_q;
	col_t cols [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win1_q <= '0;
			win2_q <= '0;
		end else if (shift) begin
			win1_q <= win2_q;
			win2_q <= new_col;
		end
	end

	// Window as it stands after this shift
	assign cols[0] = win1_q;
	assign cols[1] = win2_q;
	assign cols[2] = new_col;

	// Sum of the pixels that lie inside the image
	always_comb begin
		logic col_on;
		logic row_on;
		sum = '0;
		for (int c = 0; c < 3; c++) begin
			col_on = !((c == 0 && mask.left_off) || (c == 2 && mask.right_off));
			for (int r = 0; r < 3; r++) begin
				row_on = !((r == 0 && mask.top_off) || (r == 2 && mask.bottom_off));
				if (col_on && row_on) begin
					sum = sum + SUM_W'(cols[c][r]);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bbx_mean.sv =====
// Divide-by-nine, clamp and the result output register.
`default_nettype none

module bbx_mean (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          res_valid,
	input  wire bbx_pkg::res_t res,
	output      logic          res_ready,
	bbx_out_if.source          out
);
	import bbx_pkg::*;

	logic [PROD_W-1:0]   prod;
	logic [PIX_W:0]      quot;
	logic [PIX_W-1:0]    grey;
	logic                valid_q;
	logic [PIX_W-1:0]    grey_q;
	logic [COL_W-1:0]    column_q;
	logic [HEIGHT_W-1:0] row_q;
	logic                last_q;

	// Reciprocal multiply: exact for every sum a 3x3 window can give
	assign prod = PROD_W'(res.sum) * PROD_W'(RECIP_9);
	assign quot = prod[RECIP_SHIFT +: (PIX_W + 1)];
	assign grey = (quot > GREY_MAX) ? GREY_MAX[PIX_W-1:0] : quot[PIX_W-1:0];

	assign res_ready = !valid_q || out.ready;

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			grey_q   <= grey;
			column_q <= res.column;
			row_q    <= res.row;
			last_q   <= res.last;
		end
	end

	assign out.valid      = valid_q;
	assign out.grey_value = grey_q;
	assign out.column     = column_q;
	assign out.row        = row_q;
	assign out.last       = last_q;

endmodule

`default_nettype wire

// ===== rtl/box_blur_3x3_unit.sv =====
// Top level of the 3x3 box blur: scan counters, line store, window and result path.
`default_nettype none

// 3x3 mean filter over a raster pixel stream. One beat on pix_in is taken
// every clock cycle while the result side keeps up; each beat gives at most
// one beat on grey_out, passed through the input register, window sum register
// and output register. A result belongs to the pixel one row
// and one beat earlier, so after the last image pixel send image_width + 1 flush
// beats to drain the bottom row. The rate is set by the single line-store RAM
// (1024 x 16, one read and one write each pixel), which both line rows share.
// Pixels outside the image count as zero. image_width of 0 acts as 1 and above
// 1024 as 1024; image_height of 0 acts as 1. Write the registers only while no
// beat is in flight. After the beat flagged last no more results appear until
// reset or until a larger image size is written.
module box_blur_3x3_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	bbx_pix_if.sink   pix_in,
	bbx_out_if.source grey_out,
	bbx_cfg_if.sink   cfg
);
	import bbx_pkg::*;

	// Configuration and derived limits
	logic [CFG_WIDTH_W-1:0] width_q;
	logic [HEIGHT_W-1:0]    height_q;
	logic [CFG_WIDTH_W-1:0] w_eff;
	logic [COL_W-1:0]       wm1;
	logic [HEIGHT_W-1:0]    h_eff;
	logic [HEIGHT_W-1:0]    hm1;
	logic [COUNT_W-1:0]     total_q;

	// Scan position
	logic [COL_W-1:0]     col_q;
	logic [ROW_CNT_W-1:0] row_q;
	logic [COL_W-1:0]     xe;
	logic                 wrap;
	logic                 accept;

	// Input stage
	logic                 valid_s1;
	logic [COL_W-1:0]     x_s1;
	logic [ROW_CNT_W-1:0] y_s1;
	pix_t                 pix_s1;
	logic                 rdy_s1;

	// Commit of the input stage
	logic                 commit;
	logic [LINE_W-1:0]    line_rd;
	col_t                 new_col;
	logic                 have_a;
	logic                 have_b;
	logic                 gate;
	logic [COL_W-1:0]     cx;
	logic [ROW_CNT_W-1:0] cy;
	mask_t                mask;
	logic [SUM_W-1:0]     win_sum;
	logic [COUNT_W-1:0]   count_q;
	logic [COUNT_W-1:0]   count_inc;

	// Sum stage
	logic                 valid_s2;
	res_t                 res_s2;
	logic                 rdy_s2;
	logic                 mean_ready;

	// Register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_WIDTH_W'(MAX_WIDTH);
			height_q <= HEIGHT_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.reg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg.wdata[CFG_WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg.wdata[HEIGHT_W-1:0];
			endcase
		end
	end

	// Effective image size
	always_comb begin
		if (width_q == '0) begin
			w_eff = CFG_WIDTH_W'(1);
		end else if (width_q > CFG_WIDTH_W'(MAX_WIDTH)) begin
			w_eff = CFG_WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
	end

	assign wm1   = COL_W'(w_eff - CFG_WIDTH_W'(1));
	assign h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	assign hm1   = h_eff - HEIGHT_W'(1);

	// Pixel count of the image, registered off the config path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= COUNT_W'(MAX_WIDTH);
		end else begin
			total_q <= COUNT_W'(w_eff) * COUNT_W'(h_eff);
		end
	end

	// Scan counters advance on every input beat
	assign accept = pix_in.valid && pix_in.ready;
	assign xe     = ({1'b0, col_q} >= w_eff) ? wm1 : col_q;
	assign wrap   = (xe == wm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (wrap) begin
				col_q <= '0;
				if (row_q != ROW_CNT_MAX) begin
					row_q <= row_q + ROW_CNT_W'(1);
				end
			end else begin
				col_q <= xe + COL_W'(1);
			end
		end
	end

	// Handshake through the stages
	assign rdy_s2       = !valid_s2 || mean_ready;
	assign rdy_s1       = !valid_s1 || rdy_s2;
	assign pix_in.ready = rdy_s1;
	assign commit       = valid_s1 && rdy_s2;

	// Input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1   <= xe;
			y_s1   <= row_q;
			pix_s1 <= pix_in.flush ? '0 : pix_in.red_value;
		end
	end

	// Both line rows in one RAM: upper in the high byte, middle in the low byte
	bbx_line_ram #(
		.DEPTH(MAX_WIDTH),
		.WIDTH(LINE_W)
	) u_line_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (x_s1),
		.wdata ({line_rd[PIX_W-1:0], pix_s1}),
		.re    (accept),
		.raddr (xe),
		.rdata (line_rd)
	);

	assign new_col[0] = line_rd[LINE_W-1:PIX_W];
	assign new_col[1] = line_rd[PIX_W-1:0];
	assign new_col[2] = pix_s1;

	// Centre of the result this beat completes
	assign have_a = (x_s1 != '0) && (y_s1 != '0);
	assign have_b = (x_s1 == '0) && (y_s1 >= ROW_CNT_W'(2));
	assign cx     = have_a ? (x_s1 - COL_W'(1)) : wm1;
	assign cy     = have_a ? (y_s1 - ROW_CNT_W'(1)) : (y_s1 - ROW_CNT_W'(2));
	assign gate   = (have_a || have_b) && (count_q < total_q);

	assign mask.left_off   = (cx == '0);
	assign mask.right_off  = (cx >= wm1);
	assign mask.top_off    = (cy == '0);
	assign mask.bottom_off = (cy >= {1'b0, hm1});

	bbx_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (commit),
		.new_col (new_col),
		.mask    (mask),
		.sum     (win_sum)
	);

	// Result counter
	assign count_inc = count_q + COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit && gate) begin
			count_q <= count_inc;
		end
	end

	// Sum stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= commit && gate;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_s2.sum    <= win_sum;
			res_s2.column <= cx;
			res_s2.row    <= cy[HEIGHT_W-1:0];
			res_s2.last   <= (count_inc == total_q);
		end
	end

	bbx_mean u_mean (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (valid_s2),
		.res       (res_s2),
		.res_ready (mean_ready),
		.out       (grey_out)
	);

	// An empty output register never holds back the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!grey_out.valid |-> pix_in.ready)
		else $error("input stalled with an empty output register");

	// Masked window sum never exceeds nine full-scale pixels
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.sum <= SUM_MAX))
		else $error("window sum out of range");

	// Column held in the input stage lies inside the image row
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ({1'b0, x_s1} < w_eff))
		else $error("input stage column beyond image width");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of box_blur_3x3_unit: directed table, then random phases checked against a predictor.
module tb_top;
	import bbx_pkg::*;

	localparam int unsigned ROW_SAT   = 131071;
	localparam int          HOLD_CYC  = 300;
	localparam int          DRAIN_CAP = 2000;
	localparam int          PRINT_CAP = 40;
	localparam int          RAND_GOAL = 1200;
	localparam int          PRESSURE_PHASE = 3;

	typedef struct packed {
		pix_t                grey;
		logic [COL_W-1:0]    column;
		logic [HEIGHT_W-1:0] row;
		logic                last;
	} grey_beat_t;

	typedef enum logic [1:0] {
		DIR_WIDTH,
		DIR_HEIGHT,
		DIR_PIXEL
	} dir_kind_t;

	// One row of the directed table; t_* hold a result typed in by hand
	typedef struct packed {
		dir_kind_t  kind;
		logic [15:0] value;
		logic        flush;
		logic        typed;
		logic        t_have;
		grey_beat_t  t_beat;
	} dir_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bbx_pix_if pix ();
	bbx_out_if res ();
	bbx_cfg_if cfg_bus ();

	box_blur_3x3_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix),
		.grey_out (res),
		.cfg      (cfg_bus)
	);

	always #5 clk = ~clk;

	// Predictor state: line stores, window [column][row], scan counters, registers
	pix_t                   upper_mem [MAX_WIDTH];
	pix_t                   middle_mem [MAX_WIDTH];
	pix_t                   win [3][3];
	int unsigned            scan_col;
	int unsigned            scan_row;
	int unsigned            grey_count;
	logic [CFG_WIDTH_W-1:0] width_reg;
	logic [HEIGHT_W-1:0]    height_reg;

	grey_beat_t grey_expected [$];

	int err_count     = 0;
	int beats_in      = 0;
	int beats_out     = 0;
	int phase_count   = 0;
	int hold_requests = 0;
	bit src_calm      = 1'b0;
	bit snk_calm      = 1'b0;

	// After-reset image (1024 x 1) runs first; it then goes through width 0 and height 0,
	// resumes with height 1030, and finishes at width 2047 and height 65535
	dir_row_t dir_tab [22] = '{
		'{DIR_WIDTH,  16'd0,     1'b0, 1'b0, 1'b0, '0},
		'{DIR_HEIGHT, 16'd0,     1'b0, 1'b0, 1'b0, '0},
		'{DIR_PIXEL,  16'd255,   1'b0, 1'b1, 1'b0, '0},
		'{DIR_PIXEL,  16'd255,   1'b0, 1'b1, 1'b0, '0},
		'{DIR_PIXEL,  16'd255,   1'b0, 1'b1, 1'b0, '0},
		'{DIR_HEIGHT, 16'd1030,  1'b0, 1'b0, 1'b0, '0},
		'{DIR_PIXEL,  16'd255,   1'b0, 1'b1, 1'b1, '{8'd85, 10'd0, 16'd3, 1'b0}},
		'{DIR_PIXEL,  16'd255,   1'b0, 1'b1, 1'b1, '{8'd85, 10'd0, 16'd4, 1'b0}},
		'{DIR_PIXEL,  16'd255,   1'b0, 1'b1, 1'b1, '{8'd85, 10'd0, 16'd5, 1'b0}},
		'{DIR_PIXEL,  16'd255,   1'b1, 1'b1, 1'b1, '{8'd85, 10'd0, 16'd6, 1'b0}},
		'{DIR_PIXEL,  16'd0,     1'b0, 1'b1, 1'b1, '{8'd56, 10'd0, 16'd7, 1'b0}},
		'{DIR_PIXEL,  16'd0,     1'b0, 1'b1, 1'b1, '{8'd28, 10'd0, 16'd8, 1'b1}},
		'{DIR_PIXEL,  16'd255,   1'b0, 1'b1, 1'b0, '0},
		'{DIR_WIDTH,  16'd2047,  1'b0, 1'b0, 1'b0, '0},
		'{DIR_HEIGHT, 16'd65535, 1'b0, 1'b0, 1'b0, '0},
		'{DIR_PIXEL,  16'd0,     1'b0, 1'b0, 1'b0, '0},
		'{DIR_PIXEL,  16'd255,   1'b0, 1'b0, 1'b0, '0},
		'{DIR_PIXEL,  16'd85,    1'b0, 1'b0, 1'b0, '0},
		'{DIR_PIXEL,  16'd170,   1'b0, 1'b0, 1'b0, '0},
		'{DIR_PIXEL,  16'd1,     1'b0, 1'b0, 1'b0, '0},
		'{DIR_PIXEL,  16'd254,   1'b1, 1'b0, 1'b0, '0},
		'{DIR_PIXEL,  16'd128,   1'b0, 1'b0, 1'b0, '0}
	};

	// Width and height as the block uses them
	function automatic int unsigned cur_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > MAX_WIDTH)
			return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned cur_height();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	function automatic void blur_reset();
		foreach (upper_mem[i]) begin
			upper_mem[i]  = '0;
			middle_mem[i] = '0;
		end
		foreach (win[c, r])
			win[c][r] = '0;
		scan_col   = 0;
		scan_row   = 0;
		grey_count = 0;
		width_reg  = CFG_WIDTH_W'(MAX_WIDTH);
		height_reg = HEIGHT_W'(1);
	endfunction

	// Advance the model by one pixel beat; returns 1 when a grey beat is due
	function automatic bit blur_predict(input pix_t red, input logic flush,
			output grey_beat_t beat);
		int unsigned w, h, x, y, cx, cy, sum, mean;
		pix_t        v, up, mid;
		bit          have;
		w = cur_width();
		h = cur_height();
		x = scan_col;
		y = scan_row;
		beat = '0;
		// column left over from a wider setting
		if (x >= w)
			x = w - 1;
		v   = flush ? '0 : red;
		up  = upper_mem[x];
		mid = middle_mem[x];
		upper_mem[x]  = mid;
		middle_mem[x] = v;
		win[0] = win[1];
		win[1] = win[2];
		win[2] = '{up, mid, v};

		// centre lags by one beat, or wraps to the end of the row before last
		have = 1'b0;
		cx   = 0;
		cy   = 0;
		if (x >= 1 && y >= 1) begin
			have = 1'b1;
			cx   = x - 1;
			cy   = y - 1;
		end else if (x == 0 && y >= 2) begin
			have = 1'b1;
			cx   = w - 1;
			cy   = y - 2;
		end

		// no result once the count reaches width x height
		if (have && longint'(grey_count) < longint'(w) * longint'(h)) begin
			sum = 0;
			for (int c = 0; c < 3; c++)
				for (int r = 0; r < 3; r++)
					if (!(c == 0 && cx == 0) && !(c == 2 && cx + 1 >= w) &&
							!(r == 0 && cy == 0) && !(r == 2 && cy + 1 >= h))
						sum += win[c][r];
			mean = sum / 9;
			if (mean > 255)
				mean = 255;
			beat.grey   = mean[PIX_W-1:0];
			beat.column = cx[COL_W-1:0];
			beat.row    = cy[HEIGHT_W-1:0];
			beat.last   = (longint'(grey_count) + 1 == longint'(w) * longint'(h));
			grey_count  = (grey_count + 1) & 32'h03FF_FFFF;
		end else begin
			have = 1'b0;
		end

		// row count holds at its 17-bit maximum
		if (x + 1 >= w) begin
			scan_col = 0;
			if (y < ROW_SAT)
				scan_row = y + 1;
		end else begin
			scan_col = x + 1;
		end
		return have;
	endfunction

	// Offer one pixel beat after a random gap; queue what it should give
	task automatic send_pixel(input pix_t red, input logic flush, input bit typed,
			input bit t_have, input grey_beat_t t_beat);
		int         gap;
		bit         have;
		grey_beat_t beat;
		if ($urandom_range(0, 63) == 0)
			src_calm = !src_calm;
		gap = src_calm ? 0 : $urandom_range(0, 14);
		repeat (gap) begin
			@(negedge clk);
			pix.valid     = 1'b0;
			pix.red_value = $urandom;
			pix.flush     = $urandom_range(0, 1);
		end
		@(negedge clk);
		pix.valid     = 1'b1;
		pix.red_value = red;
		pix.flush     = flush;
		do @(posedge clk); while (!pix.ready);
		have = blur_predict(red, flush, beat);
		if (typed) begin
			have = t_have;
			beat = t_beat;
		end
		if (have)
			grey_expected.push_back(beat);
		beats_in++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_bus.valid     = 1'b1;
		cfg_bus.reg_index = idx;
		cfg_bus.wdata     = data;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_IMAGE_WIDTH:  width_reg  = data[CFG_WIDTH_W-1:0];
			REG_IMAGE_HEIGHT: height_reg = data[HEIGHT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid = 1'b0;
		cfg_bus.wdata = $urandom;
	endtask

	// Stop offering, wait for every queued grey beat, then let the pipeline empty
	task automatic settle();
		int guard;
		guard = 0;
		@(negedge clk);
		pix.valid = 1'b0;
		while (grey_expected.size() != 0 && guard < DRAIN_CAP) begin
			@(posedge clk);
			guard++;
		end
		if (grey_expected.size() != 0) begin
			err_count += grey_expected.size();
			$display("t=%0t: %0d grey beats never arrived", $time, grey_expected.size());
			grey_expected.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic check_field(input string what, input longint want, input longint got);
		if (want != got) begin
			err_count++;
			if (err_count <= PRINT_CAP)
				$display("t=%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	task automatic check_beat(input grey_beat_t got);
		grey_beat_t want;
		beats_out++;
		if (grey_expected.size() == 0) begin
			err_count++;
			if (err_count <= PRINT_CAP)
				$display("t=%0t: unexpected grey beat, expected none, got grey %0d col %0d row %0d",
					$time, got.grey, got.column, got.row);
		end else begin
			want = grey_expected.pop_front();
			check_field("grey_value", want.grey, got.grey);
			check_field("column", want.column, got.column);
			check_field("row", want.row, got.row);
			check_field("last", want.last, got.last);
		end
	endtask

	// Result side: random stalls, one long hold-off on request
	initial begin : grey_sink
		int         gap;
		int         holds_done;
		grey_beat_t got;
		holds_done = 0;
		res.ready  = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 63) == 0)
				snk_calm = !snk_calm;
			gap = snk_calm ? 0 : $urandom_range(0, 14);
			if (holds_done < hold_requests) begin
				gap = HOLD_CYC;
				holds_done++;
			end
			repeat (gap) begin
				@(negedge clk);
				res.ready = 1'b0;
			end
			@(negedge clk);
			res.ready = 1'b1;
			do @(posedge clk); while (!res.valid);
			got.grey   = res.grey_value;
			got.column = res.column;
			got.row    = res.row;
			got.last   = res.last;
			check_beat(got);
		end
	end

	// Stimulus: fill image at reset settings, directed table, random phases
	initial begin : stimulus
		int unsigned w_new, w_eff, h_new, target, n, pick;
		int          rand_items;
		rand_items        = 0;
		pix.valid         = 1'b0;
		pix.red_value     = '0;
		pix.flush         = 1'b0;
		cfg_bus.valid     = 1'b0;
		cfg_bus.reg_index = REG_IMAGE_WIDTH;
		cfg_bus.wdata     = '0;
		blur_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 1024 x 1 image at the reset settings; two rows write every line-store entry
		for (int i = 0; i < MAX_WIDTH; i++)
			send_pixel($urandom, 1'b0, 1'b0, 1'b0, '0);
		for (int i = 0; i <= MAX_WIDTH; i++)
			send_pixel($urandom, 1'b1, 1'b0, 1'b0, '0);
		settle();

		foreach (dir_tab[i]) begin
			case (dir_tab[i].kind)
				DIR_WIDTH: begin
					settle();
					write_reg(REG_IMAGE_WIDTH, dir_tab[i].value);
				end
				DIR_HEIGHT: begin
					settle();
					write_reg(REG_IMAGE_HEIGHT, dir_tab[i].value);
				end
				default: send_pixel(dir_tab[i].value[PIX_W-1:0], dir_tab[i].flush,
					dir_tab[i].typed, dir_tab[i].t_have, dir_tab[i].t_beat);
			endcase
		end

		// Random phases: new settings, a run of pixels, sometimes a drain of flush beats
		while (rand_items < RAND_GOAL) begin
			settle();
			phase_count++;
			pick = $urandom_range(0, 15);
			if (phase_count == PRESSURE_PHASE)
				w_new = 6;
			else if (pick == 0)
				w_new = 0;
			else if (pick == 1)
				w_new = MAX_WIDTH;
			else if (pick == 2)
				w_new = $urandom_range(MAX_WIDTH + 1, 2047);
			else if (pick < 8)
				w_new = $urandom_range(1, 5);
			else
				w_new = $urandom_range(2, 40);
			// spare upper data bits carry noise on width writes
			if (phase_count == PRESSURE_PHASE || $urandom_range(0, 3) != 0)
				write_reg(REG_IMAGE_WIDTH, ($urandom & 32'hF800) | w_new);
			w_eff  = cur_width();
			target = (phase_count == PRESSURE_PHASE) ? 200 : $urandom_range(10, 120);
			h_new  = (grey_count + target + w_eff - 1) / w_eff + $urandom_range(0, 2);
			if (h_new > 65535)
				h_new = 65535;
			if (phase_count != PRESSURE_PHASE && $urandom_range(0, 11) == 0)
				h_new = 0;
			write_reg(REG_IMAGE_HEIGHT, h_new);
			if (w_eff == MAX_WIDTH)
				n = $urandom_range(10, 60);
			else
				n = $urandom_range(target / 2, target + 20);
			if (phase_count == PRESSURE_PHASE) begin
				n = 200;
				src_calm = 1'b1;
				hold_requests++;
			end
			for (int i = 0; i < n; i++)
				send_pixel($urandom, $urandom_range(0, 7) == 0, 1'b0, 1'b0, '0);
			if (w_eff <= 40 && $urandom_range(0, 2) == 0) begin
				for (int i = 0; i <= w_eff; i++)
					send_pixel($urandom, 1'b1, 1'b0, 1'b0, '0);
				n += w_eff + 1;
			end
			rand_items += n;
		end
		settle();

		$display("Run: %0d pixel beats in, %0d grey beats checked, %0d random phases.",
			beats_in, beats_out, phase_count);
		$display("Widths 0..2047 and heights 0..65535 used, with image end, resume and a long output stall.");
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#6_000_000;
		$display("t=%0t: run timed out", $time);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
